FILE: rtl/core/swsg_pkg.sv
// Package for the sliding window sigma gate.
// Holds the sequencer state type, config register indexes, commands and reset values.
// No dependencies.
package swsg_pkg;

  localparam int WS_W       = 5;
  localparam int DELTA_W    = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_DELTA = 2'd1;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [WS_W-1:0]    WS_RESET    = 5'd8;
  localparam logic [DELTA_W-1:0] DELTA_RESET = 20'd256;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_MEAN_DIV,
    S_MEAN_SET,
    S_VAR_RD,
    S_VAR_D,
    S_VAR_MUL,
    S_VAR_DIV,
    S_SQRT,
    S_GATE_BOUND,
    S_GATE_CMP,
    S_WRITE,
    S_DONE
  } swsg_state_t;

endpackage

FILE: rtl/core/swsg_in_if.sv
// Input channel of the sliding window sigma gate: valid/ready plus one point item.
// No dependencies.
interface swsg_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [COORD_WIDTH-1:0] x_coord;
  logic [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, command, x_coord, y_coord, input ready);
  modport sink   (input valid, command, x_coord, y_coord, output ready);
endinterface

FILE: rtl/core/swsg_out_if.sv
// Result channel of the sliding window sigma gate: valid/ready plus the gate verdict.
// No dependencies.
interface swsg_out_if;
  logic valid;
  logic ready;
  logic point_valid;

  modport source (output valid, point_valid, input ready);
  modport sink   (input valid, point_valid, output ready);
endinterface

FILE: rtl/core/sliding_window_sigma_gate_unit.sv
// Three-sigma outlier gate over a sliding window of 2-D points.
// Depends on swsg_pkg, swsg_in_if, swsg_out_if.
//
//   channel | dir | fields                          | handshake
//   in_ch   | in  | command, x_coord, y_coord       | valid/ready
//   out_ch  | out | point_valid                     | valid/ready
//   cfg_*   | in  | cfg_index, cfg_wdata            | cfg_we, no wait
//
// A clear returns to idle without a result. A full-window add runs on one shared
// divider, one half-width multiplier and one root unit.
// Synchronous active-low reset; no clearing pass. A waiting result does not block
// the next item; a finished item holds in S_DONE while the result register is full.
module sliding_window_sigma_gate_unit
  import swsg_pkg::*;
#(
  parameter int MAX_WINDOW  = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  swsg_in_if.sink               in_ch,
  swsg_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int IW   = $clog2(MAX_WINDOW);
  localparam int CNW  = $clog2(MAX_WINDOW + 1);
  localparam int SW   = CW + CNW;
  localparam int AW   = 2 * CW + CNW;
  localparam int SQW  = AW + (AW % 2);
  localparam int RW   = SQW / 2;
  localparam int HW   = (CW + 1) / 2;
  localparam int BW   = RW + 4;
  localparam int CMPW = (CW > BW) ? CW : BW;
  localparam int DCW  = $clog2(SQW + 1);

  swsg_state_t state_r, state_nxt;

  logic [WS_W-1:0]       cfg_ws_r, cfg_ws_nxt;
  logic [DELTA_W-1:0]    cfg_delta_r, cfg_delta_nxt;
  logic [CNW-1:0]        fill_r, fill_nxt;
  logic [IW-1:0]         oldest_r, oldest_nxt;
  logic [IW-1:0]         slot_r, slot_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  axis_r, axis_nxt;
  logic                  pass_r, pass_nxt;
  logic signed [CW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [SW-1:0]  sum_r, sum_nxt;
  logic                  neg_r, neg_nxt;
  logic signed [CW-1:0]  mean_r, mean_nxt;
  logic [CW-1:0]         d_r, d_nxt;
  logic [2*HW-1:0]       mul_r, mul_nxt;
  logic [1:0]            ph_r, ph_nxt;
  logic [AW-1:0]         acc_r, acc_nxt;
  logic [AW-1:0]         div_num_r, div_num_nxt;
  logic [CNW-1:0]        div_rem_r, div_rem_nxt;
  logic [DCW-1:0]        cnt_r, cnt_nxt;
  logic [SQW-1:0]        sq_val_r, sq_val_nxt;
  logic [RW+1:0]         sq_rem_r, sq_rem_nxt;
  logic [RW-1:0]         sq_root_r, sq_root_nxt;
  logic [BW-1:0]         bound_r, bound_nxt;
  logic [CW-1:0]         dist_r, dist_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_pv_r, out_pv_nxt;

  logic [2*CW-1:0]       mem [MAX_WINDOW];
  logic [2*CW-1:0]       mem_q_r;
  logic                  mem_we;
  logic [IW-1:0]         mem_wa;
  logic [2*CW-1:0]       mem_wd;

  logic [CNW-1:0]        ws_eff;
  logic                  in_acc;
  logic                  last_idx;
  logic                  full;
  logic signed [CW-1:0]  sample;
  logic signed [SW-1:0]  sum_add;
  logic [SW-1:0]         sum_neg;
  logic [SW-1:0]         sum_abs;
  logic signed [CW-1:0]  ad_a, ad_b;
  logic signed [CW:0]    ad_diff;
  logic [CW:0]           ad_neg;
  logic [CW-1:0]         ad_mag;
  logic [CNW:0]          div_sh;
  logic                  div_ge;
  logic [RW+3:0]         sq_sh, sq_trial;
  logic                  sq_ge;
  logic [HW-1:0]         m_a, m_b, d_lo, d_hi;
  logic [AW-1:0]         acc_term;
  logic [CW-1:0]         q_mag;

  // effective window size: 0 acts as 1, clipped to MAX_WINDOW
  always_comb begin
    if (cfg_ws_r == '0) begin
      ws_eff = CNW'(1);
    end else if (32'(cfg_ws_r) > 32'(MAX_WINDOW)) begin
      ws_eff = CNW'(MAX_WINDOW);
    end else begin
      ws_eff = CNW'(cfg_ws_r);
    end
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign full     = (fill_r >= ws_eff);
  assign last_idx = ((CNW'(idx_r) + CNW'(1)) == ws_eff);
  assign sample   = axis_r ? $signed(mem_q_r[CW-1:0]) : $signed(mem_q_r[2*CW-1:CW]);

  // shared absolute difference against the mean
  assign ad_a    = (state_r == S_VAR_D) ? sample : (axis_r ? y_r : x_r);
  assign ad_b    = mean_r;
  assign ad_diff = $signed({ad_a[CW-1], ad_a}) - $signed({ad_b[CW-1], ad_b});
  assign ad_neg  = -ad_diff;
  assign ad_mag  = ad_diff[CW] ? ad_neg[CW-1:0] : ad_diff[CW-1:0];

  assign sum_add = sum_r + SW'(sample);
  assign sum_neg = -sum_add;
  assign sum_abs = sum_add[SW-1] ? sum_neg : sum_add;

  // shared restoring divider step, divisor is the window size
  assign div_sh = {div_rem_r, div_num_r[AW-1]};
  assign div_ge = (div_sh >= {1'b0, ws_eff});

  // root step, two radicand bits per cycle
  assign sq_sh    = {sq_rem_r, sq_val_r[SQW-1:SQW-2]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  // half-width multiplier operands for d*d
  assign d_lo = d_r[HW-1:0];
  assign d_hi = HW'(d_r >> HW);

  always_comb begin
    case (ph_r)
      2'd0:    begin m_a = d_lo; m_b = d_lo; end
      2'd1:    begin m_a = d_lo; m_b = d_hi; end
      default: begin m_a = d_hi; m_b = d_hi; end
    endcase
  end

  always_comb begin
    case (ph_r)
      2'd1:    acc_term = AW'(mul_r);
      2'd2:    acc_term = AW'(mul_r) << (HW + 1);
      2'd3:    acc_term = AW'(mul_r) << (2 * HW);
      default: acc_term = '0;
    endcase
  end

  assign q_mag = div_num_r[CW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_CLEAR) begin
            state_nxt = S_IDLE;
          end else if (full) begin
            state_nxt = S_SUM_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SUM_RD:  state_nxt = S_SUM_ACC;
      S_SUM_ACC: state_nxt = last_idx ? S_MEAN_DIV : S_SUM_RD;
      S_MEAN_DIV: begin
        if (cnt_r == DCW'(1)) state_nxt = S_MEAN_SET;
      end
      S_MEAN_SET: state_nxt = S_VAR_RD;
      S_VAR_RD:   state_nxt = S_VAR_D;
      S_VAR_D:    state_nxt = S_VAR_MUL;
      S_VAR_MUL: begin
        if (ph_r == 2'd3) state_nxt = last_idx ? S_VAR_DIV : S_VAR_RD;
      end
      S_VAR_DIV: begin
        if (cnt_r == DCW'(1)) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (cnt_r == DCW'(1)) state_nxt = S_GATE_BOUND;
      end
      S_GATE_BOUND: state_nxt = S_GATE_CMP;
      S_GATE_CMP:   state_nxt = axis_r ? S_WRITE : S_SUM_RD;
      S_WRITE:      state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready       = (state_r == S_IDLE);
    out_ch.valid      = out_valid_r;
    out_ch.point_valid = out_pv_r;
  end

  // datapath
  always_comb begin
    cfg_ws_nxt    = cfg_ws_r;
    cfg_delta_nxt = cfg_delta_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    axis_nxt      = axis_r;
    pass_nxt      = pass_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    sum_nxt       = sum_r;
    neg_nxt       = neg_r;
    mean_nxt      = mean_r;
    d_nxt         = d_r;
    mul_nxt       = mul_r;
    ph_nxt        = ph_r;
    acc_nxt       = acc_r;
    div_num_nxt   = div_num_r;
    div_rem_nxt   = div_rem_r;
    cnt_nxt       = cnt_r;
    sq_val_nxt    = sq_val_r;
    sq_rem_nxt    = sq_rem_r;
    sq_root_nxt   = sq_root_r;
    bound_nxt     = bound_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r;
    out_pv_nxt    = out_pv_r;
    mem_we        = 1'b0;
    mem_wa        = slot_r;
    mem_wd        = {x_r, y_r};

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt    = $signed(in_ch.x_coord[CW-1:0]);
          y_nxt    = $signed(in_ch.y_coord[CW-1:0]);
          idx_nxt  = '0;
          axis_nxt = 1'b0;
          pass_nxt = 1'b0;
          sum_nxt  = '0;
          if (in_ch.command == CMD_CLEAR) begin
            fill_nxt   = '0;
            oldest_nxt = '0;
          end else if (full) begin
            pass_nxt = 1'b1;
            slot_nxt = (CNW'(oldest_r) < ws_eff) ? oldest_r : '0;
          end else begin
            mem_we     = 1'b1;
            mem_wa     = fill_r[IW-1:0];
            mem_wd     = {in_ch.x_coord[CW-1:0], in_ch.y_coord[CW-1:0]};
            fill_nxt   = fill_r + CNW'(1);
            oldest_nxt = '0;
          end
        end
      end
      S_SUM_ACC: begin
        sum_nxt = sum_add;
        idx_nxt = idx_r + IW'(1);
        if (last_idx) begin
          neg_nxt     = sum_add[SW-1];
          div_num_nxt = AW'(sum_abs);
          div_rem_nxt = '0;
          cnt_nxt     = DCW'(AW);
        end
      end
      S_MEAN_DIV, S_VAR_DIV: begin
        div_num_nxt = {div_num_r[AW-2:0], div_ge};
        div_rem_nxt = div_ge ? CNW'(div_sh - {1'b0, ws_eff}) : CNW'(div_sh);
        cnt_nxt     = cnt_r - DCW'(1);
        if (state_r == S_VAR_DIV && cnt_r == DCW'(1)) begin
          sq_val_nxt  = SQW'({div_num_r[AW-2:0], div_ge});
          sq_rem_nxt  = '0;
          sq_root_nxt = '0;
          cnt_nxt     = DCW'(RW);
        end
      end
      S_MEAN_SET: begin
        mean_nxt = neg_r ? $signed(-q_mag) : $signed(q_mag);
        idx_nxt  = '0;
        acc_nxt  = '0;
      end
      S_VAR_D: begin
        d_nxt  = ad_mag;
        ph_nxt = 2'd0;
      end
      S_VAR_MUL: begin
        mul_nxt = {{HW{1'b0}}, m_a} * {{HW{1'b0}}, m_b};
        acc_nxt = acc_r + acc_term;
        ph_nxt  = ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          idx_nxt = idx_r + IW'(1);
          if (last_idx) begin
            div_num_nxt = acc_r + acc_term;
            div_rem_nxt = '0;
            cnt_nxt     = DCW'(AW);
          end
        end
      end
      S_SQRT: begin
        sq_val_nxt  = sq_val_r << 2;
        sq_rem_nxt  = sq_ge ? (RW+2)'(sq_sh - sq_trial) : (RW+2)'(sq_sh);
        sq_root_nxt = {sq_root_r[RW-2:0], sq_ge};
        cnt_nxt     = cnt_r - DCW'(1);
      end
      S_GATE_BOUND: begin
        bound_nxt = BW'({sq_root_r, 1'b0}) + BW'(sq_root_r) + BW'(cfg_delta_r);
        dist_nxt  = ad_mag;
      end
      S_GATE_CMP: begin
        pass_nxt = pass_r && (CMPW'(dist_r) <= CMPW'(bound_r));
        axis_nxt = 1'b1;
        idx_nxt  = '0;
        sum_nxt  = '0;
      end
      S_WRITE: begin
        mem_we     = 1'b1;
        oldest_nxt = ((CNW'(slot_r) + CNW'(1)) == ws_eff) ? '0 : slot_r + IW'(1);
        fill_nxt   = ws_eff;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pv_nxt    = pass_r;
        end
      end
      default: ;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: begin
          cfg_ws_nxt = cfg_wdata[WS_W-1:0];
          fill_nxt   = '0;
          oldest_nxt = '0;
        end
        CFG_SIGMA_DELTA: cfg_delta_nxt = cfg_wdata[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_ws_r    <= WS_RESET;
      cfg_delta_r <= DELTA_RESET;
      fill_r      <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_ws_r    <= cfg_ws_nxt;
      cfg_delta_r <= cfg_delta_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    idx_r     <= idx_nxt;
    axis_r    <= axis_nxt;
    pass_r    <= pass_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    sum_r     <= sum_nxt;
    neg_r     <= neg_nxt;
    mean_r    <= mean_nxt;
    d_r       <= d_nxt;
    mul_r     <= mul_nxt;
    ph_r      <= ph_nxt;
    acc_r     <= acc_nxt;
    div_num_r <= div_num_nxt;
    div_rem_r <= div_rem_nxt;
    cnt_r     <= cnt_nxt;
    sq_val_r  <= sq_val_nxt;
    sq_rem_r  <= sq_rem_nxt;
    sq_root_r <= sq_root_nxt;
    bound_r   <= bound_nxt;
    dist_r    <= dist_nxt;
    out_pv_r  <= out_pv_nxt;
  end

endmodule

FILE: rtl/core/swsg_checker.sv
// Port-level checks for the sliding window sigma gate, bound to its top level.
// Depends on swsg_pkg and sliding_window_sigma_gate_unit.
module swsg_checker
  import swsg_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_command,
  input logic out_valid,
  input logic out_ready,
  input logic out_point_valid
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_valid))
    else $error("stalled result dropped or changed");

  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_ADD |=> !in_ready)
    else $error("add item did not make the block busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in progress");

endmodule

bind sliding_window_sigma_gate_unit swsg_checker u_swsg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_command     (in_ch.command),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_point_valid(out_ch.point_valid)
);
